// ----- design/hpwa_pkg.sv -----
// Package for the hysteresis pulse-width averager.
// Holds shared constants, the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hpwa_pkg;

    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned TICK_W       = 32;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned CFG_W        = 16;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned IN_DATA_W    = 48;
    localparam int unsigned OUT_DATA_W   = 48;
    localparam int unsigned DIV_STEPS    = TICK_W;
    localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] WARMUP_PULSES = 16'd4;

    localparam logic [CFG_W-1:0] HIGH_THR_RESET = 16'd6552;
    localparam logic [CFG_W-1:0] LOW_THR_RESET  = 16'd1000;
    localparam logic [CFG_W-1:0] TARGET_RESET   = 16'd50;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_DONE   = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/hpwa_datapath.sv -----
// Datapath of the hysteresis pulse-width averager: configuration registers,
// pulse tracking state, a bit-serial restoring divider and the output payload.
// Depends on hpwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpwa_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [hpwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hpwa_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic [hpwa_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [hpwa_pkg::TICK_W-1:0]    timestamp,
    input  wire hpwa_pkg::dp_cmd_t              cmd,
    output hpwa_pkg::dp_stat_t                  stat,
    output logic [hpwa_pkg::TICK_W-1:0]         average_high_time,
    output logic [hpwa_pkg::COUNT_W-1:0]        pulses_counted
);
    import hpwa_pkg::*;

    logic [CFG_W-1:0]   high_thr_reg;
    logic [CFG_W-1:0]   low_thr_reg;
    logic [CFG_W-1:0]   target_reg;

    logic               warming_reg;
    logic               active_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TICK_W-1:0]  start_reg;
    logic [TICK_W-1:0]  sum_reg;

    logic               warming_next;
    logic               active_next;
    logic [COUNT_W-1:0] count_next;
    logic [TICK_W-1:0]  start_next;
    logic [TICK_W-1:0]  sum_next;

    logic [TICK_W-1:0]  quot_reg;
    logic [COUNT_W-1:0] divisor_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [TICK_W-1:0]  avg_reg;
    logic [COUNT_W-1:0] cnt_out_reg;

    logic               at_high;
    logic               at_low;
    logic               act_tmp;
    logic               end_pulse;
    logic [TICK_W-1:0]  start_tmp;
    logic [COUNT_W-1:0] cnt_tmp;
    logic [COUNT_W-1:0] target_eff;
    logic               emit;
    logic [COUNT_W:0]   rem_shift;
    logic               rem_ge;

    assign at_high    = sample >= high_thr_reg;
    assign at_low     = sample <= low_thr_reg;
    assign target_eff = (target_reg == '0) ? COUNT_W'(1) : target_reg;

    always_comb
    begin
        warming_next = warming_reg;
        active_next  = active_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        sum_next     = sum_reg;
        emit         = 1'b0;
        act_tmp      = active_reg | at_high;
        end_pulse    = at_low & act_tmp;
        start_tmp    = (at_high && !active_reg) ? timestamp : start_reg;
        cnt_tmp      = end_pulse ? count_reg + COUNT_W'(1) : count_reg;
        if (warming_reg)
        begin
            active_next = act_tmp & ~end_pulse;
            count_next  = cnt_tmp;
            if (cnt_tmp >= WARMUP_PULSES)
            begin
                count_next   = '0;
                warming_next = 1'b0;
            end
        end
        else
        begin
            active_next = act_tmp & ~end_pulse;
            start_next  = start_tmp;
            count_next  = cnt_tmp;
            if (end_pulse)
            begin
                sum_next = sum_reg + (timestamp - start_tmp);
            end
            if (cnt_tmp >= target_eff)
            begin
                emit         = 1'b1;
                warming_next = 1'b1;
                active_next  = 1'b0;
                count_next   = '0;
                start_next   = '0;
                sum_next     = '0;
            end
        end
    end

    assign stat.emit = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THR_RESET;
            low_thr_reg  <= LOW_THR_RESET;
            target_reg   <= TARGET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HIGH_THR: high_thr_reg <= cfg_wdata;
                REG_LOW_THR:  low_thr_reg  <= cfg_wdata;
                REG_TARGET:   target_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warming_reg <= 1'b1;
            active_reg  <= 1'b0;
            count_reg   <= '0;
            start_reg   <= '0;
            sum_reg     <= '0;
        end
        else if (cmd.step)
        begin
            warming_reg <= warming_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
            start_reg   <= start_next;
            sum_reg     <= sum_next;
        end
    end

    // One quotient bit per cycle while cmd.div_step is asserted, most significant first.
    assign rem_shift = {rem_reg, quot_reg[TICK_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.step && emit)
        begin
            quot_reg    <= sum_reg + ((end_pulse) ? (timestamp - start_tmp) : '0);
            divisor_reg <= cnt_tmp;
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[TICK_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? COUNT_W'(rem_shift - {1'b0, divisor_reg})
                               : rem_shift[COUNT_W-1:0];
        end
        if (cmd.load_out)
        begin
            avg_reg     <= quot_reg;
            cnt_out_reg <= divisor_reg;
        end
    end

    assign average_high_time = avg_reg;
    assign pulses_counted    = cnt_out_reg;

endmodule

`default_nettype wire

// ----- design/hpwa_controller.sv -----
// Controller of the hysteresis pulse-width averager: input handshake,
// divider sequencing and output valid.
// Depends on hpwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpwa_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire hpwa_pkg::dp_stat_t stat,
    output hpwa_pkg::dp_cmd_t       cmd
);
    import hpwa_pkg::*;

    ctrl_state_t          state_reg;
    ctrl_state_t          state_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIV_CNT_W-1:0] step_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        valid_next   = valid_reg && !m_tready;
        cmd.step     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.step = s_tvalid;
                if (s_tvalid && stat.emit)
                begin
                    state_next = ST_DIVIDE;
                    step_next  = '0;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire

// ----- design/hysteresis_pulse_width_averager.sv -----
// Top level of the hysteresis pulse-width averager.
// An item that causes no result is accepted while idle; the next may follow at once.
// An item that completes a run occupies the bit-serial divider (ST_DIVIDE), then
// ST_DONE loads the output register and raises the output valid; input stalls
// until then, longer while an earlier result waits to be taken.
// rst_n (asynchronous, active low) restores register defaults and tracking/control state.
`timescale 1ns / 1ps
`default_nettype none

module hysteresis_pulse_width_averager (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hpwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hpwa_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [hpwa_pkg::IN_DATA_W-1:0]  s_tdata,  // sample, timestamp
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [hpwa_pkg::OUT_DATA_W-1:0]      m_tdata   // average_high_time, pulses_counted
);
    import hpwa_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [TICK_W-1:0]   average_high_time;
    logic [COUNT_W-1:0]  pulses_counted;

    hpwa_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hpwa_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .sample            (s_tdata[SAMPLE_W-1:0]),
        .timestamp         (s_tdata[SAMPLE_W+TICK_W-1:SAMPLE_W]),
        .cmd               (cmd),
        .stat              (stat),
        .average_high_time (average_high_time),
        .pulses_counted    (pulses_counted)
    );

    assign m_tdata = {pulses_counted, average_high_time};

endmodule

`default_nettype wire
